@@ rtl/core/modexp_pkg.sv @@
// Shared types and constants for the modular exponentiation block.
// Holds the microcode word layout and its action and condition codes.
// No dependencies.
package modexp_pkg;

   localparam int unsigned OPERAND_WIDTH_DEFAULT = 31;
   localparam logic [63:0] MODULUS_RESET         = 64'd1000000007;
   localparam int unsigned PC_WIDTH              = 4;

   typedef enum logic [3:0] {
      ACT_NOP,
      ACT_LOAD,
      ACT_MUL_RED,
      ACT_MUL_SQ,
      ACT_MUL_BASE,
      ACT_WB_BASE,
      ACT_WB_ACC,
      ACT_ACC_ONE,
      ACT_ACC_ZERO,
      ACT_NEXT_BIT,
      ACT_EMIT
   } action_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_WAIT_REQ,
      COND_WAIT_MUL,
      COND_WAIT_OUT,
      COND_MOD_SMALL,
      COND_EXP_BIT_ZERO,
      COND_MORE_BITS
   } cond_type;

   typedef struct packed {
      action_type          action;
      cond_type            cond;
      logic [PC_WIDTH-1:0] target;
   } uop_type;

endpackage

@@ rtl/core/modexp_rom.sv @@
// Microcode store for the modular exponentiation sequencer.
// Maps a step address to its control word; depends on modexp_pkg.
module modexp_rom import modexp_pkg::*; (
   input  logic [PC_WIDTH-1:0] pc,
   output uop_type             uop
);

   always_comb begin
      case (pc)
         4'd0:    uop = '{ACT_LOAD,     COND_WAIT_REQ,     4'd0};
         4'd1:    uop = '{ACT_NOP,      COND_MOD_SMALL,    4'd13};
         4'd2:    uop = '{ACT_MUL_RED,  COND_NONE,         4'd0};
         4'd3:    uop = '{ACT_WB_BASE,  COND_WAIT_MUL,     4'd0};
         4'd4:    uop = '{ACT_ACC_ONE,  COND_NONE,         4'd0};
         4'd5:    uop = '{ACT_MUL_SQ,   COND_NONE,         4'd0};
         4'd6:    uop = '{ACT_WB_ACC,   COND_WAIT_MUL,     4'd0};
         4'd7:    uop = '{ACT_NOP,      COND_EXP_BIT_ZERO, 4'd10};
         4'd8:    uop = '{ACT_MUL_BASE, COND_NONE,         4'd0};
         4'd9:    uop = '{ACT_WB_ACC,   COND_WAIT_MUL,     4'd0};
         4'd10:   uop = '{ACT_NEXT_BIT, COND_MORE_BITS,    4'd5};
         4'd11:   uop = '{ACT_EMIT,     COND_WAIT_OUT,     4'd0};
         4'd12:   uop = '{ACT_NOP,      COND_ALWAYS,       4'd0};
         4'd13:   uop = '{ACT_ACC_ZERO, COND_ALWAYS,       4'd11};
         default: uop = '{ACT_NOP,      COND_ALWAYS,       4'd0};
      endcase
   end

endmodule

@@ rtl/core/modexp_mulmod.sv @@
// Serial modular multiplier: one bit of the multiplier operand per cycle.
// Each cycle doubles the partial sum and, when the current bit of y is one, adds x, both reduced; uses modexp_pkg.
module modexp_mulmod import modexp_pkg::*; #(
   parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [OPERAND_WIDTH-1:0] x,
   input  logic [OPERAND_WIDTH-1:0] y,
   input  logic [OPERAND_WIDTH-1:0] modulus,
   output logic                     busy,
   output logic [OPERAND_WIDTH-1:0] product
);

   localparam int unsigned CNT_WIDTH = $clog2(OPERAND_WIDTH);

   logic                     busy_ff, busy_in;
   logic [CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic [OPERAND_WIDTH-1:0] acc_ff, acc_in;
   logic [OPERAND_WIDTH-1:0] x_ff, x_in;
   logic [OPERAND_WIDTH-1:0] y_ff, y_in;
   logic [OPERAND_WIDTH:0]   dbl, dbl_red, sum, sum_red, mod_ext;

   always_comb begin
      mod_ext = {1'b0, modulus};
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
      sum     = dbl_red + (y_ff[OPERAND_WIDTH-1] ? {1'b0, x_ff} : '0);
      sum_red = (sum >= mod_ext) ? sum - mod_ext : sum;

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(OPERAND_WIDTH - 1);
         acc_in  = '0;
         x_in    = x;
         y_in    = y;
      end else if (busy_ff) begin
         acc_in = sum_red[OPERAND_WIDTH-1:0];
         y_in   = {y_ff[OPERAND_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign busy    = busy_ff;
   assign product = acc_ff;

endmodule

@@ rtl/core/modular_exponentiation.sv @@
// Top level of the modular exponentiation block: sequencer and datapath.
// Uses modexp_pkg, modexp_rom and modexp_mulmod.
//
//   Channel   Ports                                  Direction
//   req       req_valid/req_ready, base, exponent    in
//   rsp       rsp_valid/rsp_ready, power             out
//   csr       csr_wr_en, csr_wr_data (modulus)       in
//
// A modulus below two skips the arithmetic and gives a power of zero.
// Each product comes from the serial multiplier, one bit per cycle.
// Reset is synchronous; it clears the sequencer and loads the modulus reset value.
// A finished result waits in the output register while the next request is taken.
module modular_exponentiation import modexp_pkg::*; #(
   parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OPERAND_WIDTH-1:0] req_base,
   input  logic [OPERAND_WIDTH-1:0] req_exponent,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [OPERAND_WIDTH-1:0] rsp_power,
   input  logic                     csr_wr_en,
   input  logic [OPERAND_WIDTH-1:0] csr_wr_data
);

   localparam int unsigned CNT_WIDTH = $clog2(OPERAND_WIDTH);

   logic [PC_WIDTH-1:0]      pc_ff, pc_in;
   logic [OPERAND_WIDTH-1:0] modulus_ff, modulus_in;
   logic [OPERAND_WIDTH-1:0] base_ff, base_in;
   logic [OPERAND_WIDTH-1:0] exp_ff, exp_in;
   logic [OPERAND_WIDTH-1:0] acc_ff, acc_in;
   logic [CNT_WIDTH-1:0]     bit_cnt_ff, bit_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OPERAND_WIDTH-1:0] rsp_power_ff, rsp_power_in;

   uop_type                  uop;
   logic                     hold, jump, fire;
   logic                     mul_start, mul_busy;
   logic [OPERAND_WIDTH-1:0] mul_x, mul_y, mul_product;

   modexp_rom u_rom (
      .pc  (pc_ff),
      .uop (uop)
   );

   modexp_mulmod #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .modulus (modulus_ff),
      .busy    (mul_busy),
      .product (mul_product)
   );

   always_comb begin
      hold = ((uop.cond == COND_WAIT_REQ) && !req_valid)
          || ((uop.cond == COND_WAIT_MUL) && mul_busy)
          || ((uop.cond == COND_WAIT_OUT) && rsp_valid_ff);
      jump = (uop.cond == COND_ALWAYS)
          || ((uop.cond == COND_MOD_SMALL) && (modulus_ff[OPERAND_WIDTH-1:1] == '0))
          || ((uop.cond == COND_EXP_BIT_ZERO) && !exp_ff[OPERAND_WIDTH-1])
          || ((uop.cond == COND_MORE_BITS) && (bit_cnt_ff != '0));
      fire = !hold;

      if (hold) begin
         pc_in = pc_ff;
      end else if (jump) begin
         pc_in = uop.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end

      modulus_in   = csr_wr_en ? csr_wr_data : modulus_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      bit_cnt_in   = bit_cnt_ff;
      rsp_power_in = rsp_power_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_start    = 1'b0;
      mul_x        = acc_ff;
      mul_y        = base_ff;

      if (fire) begin
         case (uop.action)
            ACT_LOAD: begin
               base_in    = req_base;
               exp_in     = req_exponent;
               bit_cnt_in = CNT_WIDTH'(OPERAND_WIDTH - 1);
            end
            ACT_MUL_RED: begin
               mul_start = 1'b1;
               mul_x     = OPERAND_WIDTH'(1);
            end
            ACT_MUL_SQ: begin
               mul_start = 1'b1;
               mul_y     = acc_ff;
            end
            ACT_MUL_BASE: begin
               mul_start = 1'b1;
            end
            ACT_WB_BASE: begin
               base_in = mul_product;
            end
            ACT_WB_ACC: begin
               acc_in = mul_product;
            end
            ACT_ACC_ONE: begin
               acc_in = OPERAND_WIDTH'(1);
            end
            ACT_ACC_ZERO: begin
               acc_in = '0;
            end
            ACT_NEXT_BIT: begin
               exp_in     = {exp_ff[OPERAND_WIDTH-2:0], 1'b0};
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
            ACT_EMIT: begin
               rsp_valid_in = 1'b1;
               rsp_power_in = acc_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         modulus_ff   <= MODULUS_RESET[OPERAND_WIDTH-1:0];
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff      <= base_in;
      exp_ff       <= exp_in;
      acc_ff       <= acc_in;
      bit_cnt_ff   <= bit_cnt_in;
      rsp_power_ff <= rsp_power_in;
   end

   assign req_ready = (uop.cond == COND_WAIT_REQ);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_power = rsp_power_ff;

endmodule

@@ tb/modular_exponentiation_test.sv @@
// Self-checking testbench for the modular exponentiation block.
// Depends on modexp_pkg and the modular_exponentiation top level; it predicts
// each power with the function expected_power_of and checks every response against it in order.
`timescale 1ns / 100ps

module modular_exponentiation_test import modexp_pkg::*; ();

   localparam int unsigned W = OPERAND_WIDTH_DEFAULT;
   localparam int CYCLE_LIMIT = 8000000;
   localparam int DRAIN_CYCLES = 2200;
   localparam logic [W-1:0] MODULUS_MAX = {W{1'b1}};

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [W-1:0] req_base;
   logic [W-1:0] req_exponent;
   logic rsp_valid;
   logic rsp_ready;
   logic [W-1:0] rsp_power;
   logic csr_wr_en;
   logic [W-1:0] csr_wr_data;

   logic [W-1:0] modulus_setting;
   logic [W-1:0] expected_powers[$];
   logic [W-1:0] wanted_power;
   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_off_left;
   int error_count;
   int cycle_count;
   int requests_sent;
   int powers_checked;
   int moduli_written;

   modular_exponentiation #(
      .OPERAND_WIDTH(W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_base(req_base),
      .req_exponent(req_exponent),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_power(rsp_power),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [W-1:0] expected_power_of(input logic [W-1:0] base,
                                                      input logic [W-1:0] exponent,
                                                      input logic [W-1:0] modulus);
      logic [63:0] m;
      logic [63:0] square;
      logic [63:0] product;
      int bit_index;
      if (modulus < 2) begin
         return '0;
      end
      m = 64'(modulus);
      square = 64'(base) % m;
      product = 64'd1;
      for (bit_index = 0; bit_index < W; bit_index++) begin
         if (exponent[bit_index]) begin
            product = (product * square) % m;
         end
         square = (square * square) % m;
      end
      return product[W-1:0];
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("timeout after %0d cycles with %0d powers outstanding",
                cycle_count, expected_powers.size());
         error_count++;
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_powers.size() == 0) begin
            $error("power: expected none, actual %0d", rsp_power);
            error_count++;
         end else begin
            wanted_power = expected_powers.pop_front();
            powers_checked++;
            if (rsp_power !== wanted_power) begin
               $error("power: expected %0d, actual %0d", wanted_power, rsp_power);
               error_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic send_request(input logic [W-1:0] base, input logic [W-1:0] exponent);
      req_base <= base;
      req_exponent <= exponent;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_powers.push_back(expected_power_of(base, exponent, modulus_setting));
      requests_sent++;
      @(negedge clock);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1500, 1)) @(negedge clock);
         end else begin
            do @(negedge clock); while ($urandom_range(99) < sender_idle_pct);
         end
      end
   endtask

   task automatic finish_phase();
      req_valid <= 1'b0;
      while (expected_powers.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_modulus(input logic [W-1:0] value);
      finish_phase();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      modulus_setting = value;
      moduli_written++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [W-1:0] pick_modulus();
      case ($urandom_range(5))
         0: return MODULUS_MAX;
         1: return W'($urandom_range(16, 2));
         5: return MODULUS_RESET[W-1:0];
         default: return W'($urandom_range(MODULUS_MAX, 2));
      endcase
   endfunction

   function automatic logic [W-1:0] pick_base();
      case ($urandom_range(9))
         0: return modulus_setting - 1'b1;
         1: return modulus_setting;
         2: return modulus_setting + 1'b1;
         3: return W'($urandom_range(3));
         4, 5: return (modulus_setting < 2) ? W'($urandom) :
                      W'($urandom_range(modulus_setting - 1'b1, 0));
         default: return W'($urandom);
      endcase
   endfunction

   function automatic logic [W-1:0] pick_exponent();
      case ($urandom_range(9))
         0, 1: return W'($urandom_range(64));
         2, 3: return W'(1) << $urandom_range(W - 1);
         default: return W'($urandom);
      endcase
   endfunction

   task automatic test_reset_modulus();
      send_request('0, '0);
      send_request('0, W'(1));
      send_request(W'(12345), '0);
      send_request(MODULUS_MAX, MODULUS_MAX);
      send_request(MODULUS_RESET[W-1:0], W'(5));
      send_request(MODULUS_RESET[W-1:0] + 1'b1, W'(1000));
      send_request(W'(2), W'(30));
      send_request(MODULUS_MAX, W'(1));
      send_request(W'(3), MODULUS_RESET[W-1:0] - 1'b1);
   endtask

   task automatic test_modulus_extremes();
      write_modulus(MODULUS_MAX);
      send_request(MODULUS_MAX, W'(7));
      send_request(MODULUS_MAX - 1'b1, MODULUS_MAX);
      send_request(W'(7), MODULUS_MAX - 1'b1);
      write_modulus(W'(2));
      send_request(W'(3), MODULUS_MAX);
      send_request(W'(4), W'(5));
      send_request('0, '0);
      write_modulus(W'(1));
      send_request(W'(5), W'(3));
      send_request('0, '0);
      write_modulus('0);
      send_request(MODULUS_MAX, MODULUS_MAX);
      send_request(W'(9), '0);
   endtask

   task automatic test_random_traffic();
      int idle_table[4] = '{0, 82, 0, 13};
      int stall_table[4] = '{0, 0, 82, 13};
      int phase;
      int setting;
      int item;
      for (phase = 0; phase < 4; phase++) begin
         for (setting = 0; setting < 2; setting++) begin
            write_modulus(pick_modulus());
            sender_idle_pct = idle_table[phase];
            receiver_stall_pct = stall_table[phase];
            for (item = 0; item < 33; item++) begin
               send_request(pick_base(), pick_exponent());
            end
            finish_phase();
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
      end
   endtask

   task automatic test_output_backpressure();
      int item;
      write_modulus(MODULUS_RESET[W-1:0]);
      hold_off_left = 9000;
      for (item = 0; item < 5; item++) begin
         send_request(pick_base(), pick_exponent());
      end
      finish_phase();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_base = '0;
      req_exponent = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      modulus_setting = MODULUS_RESET[W-1:0];
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_off_left = 0;
      error_count = 0;
      cycle_count = 0;
      requests_sent = 0;
      powers_checked = 0;
      moduli_written = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_modulus();
      test_modulus_extremes();
      test_random_traffic();
      test_output_backpressure();

      finish_phase();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d powers from %0d requests across %0d modulus writes,",
               powers_checked, requests_sent, moduli_written);
      $display("with sender gaps, receiver stalls and one long output hold-off.");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
